@@ src/dtf_pkg.sv @@
package dtf_pkg;

	// Number format.
	localparam int INT_BITS        = 31;
	localparam int FRAC_BITS       = 32;
	localparam int MAX_FRAC_DIGITS = 9;
	localparam int VALUE_W         = 64;
	localparam int CHAR_W          = 8;
	localparam int STATUS_W        = 2;
	localparam int FRAC_ACC_W      = 30;
	localparam int DIGIT_CNT_W     = 4;
	localparam int BIT_CNT_W       = $clog2(FRAC_BITS);

	// Character codes.
	localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'd43;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
	localparam logic [CHAR_W-1:0] CH_POINT = 8'd46;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD = 2'd1;
	localparam logic [STATUS_W-1:0] ST_SAT = 2'd2;

	// Parser phase.
	typedef enum logic [2:0] {
		PH_WS,
		PH_SIGN,
		PH_INT,
		PH_FRAC,
		PH_SKIP
	} phase_t;

	// Control sequencer.
	typedef enum logic [1:0] {
		CT_PARSE,
		CT_DIV,
		CT_LOAD
	} ctl_t;

	// Sequencer outputs.
	typedef struct packed {
		logic in_ready;
		logic div_step;
		logic load_out;
	} ctl_out_t;

	// Ten to the given number of fraction digits.
	function automatic logic [FRAC_ACC_W-1:0] pow10(input logic [DIGIT_CNT_W-1:0] digits);
		logic [FRAC_ACC_W-1:0] r;
		case (digits)
			4'd0: r = 30'd1;
			4'd1: r = 30'd10;
			4'd2: r = 30'd100;
			4'd3: r = 30'd1000;
			4'd4: r = 30'd10000;
			4'd5: r = 30'd100000;
			4'd6: r = 30'd1000000;
			4'd7: r = 30'd10000000;
			4'd8: r = 30'd100000000;
			default: r = 30'd1000000000;
		endcase
		return r;
	endfunction

endpackage

@@ src/dtf_char_if.sv @@
interface dtf_char_if import dtf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;

	modport source (output valid, output char_code, input ready);
	modport sink (input valid, input char_code, output ready);
endinterface

@@ src/dtf_num_if.sv @@
interface dtf_num_if import dtf_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [VALUE_W-1:0]  value;
	logic [STATUS_W-1:0]        status;

	modport source (output valid, output value, output status, input ready);
	modport sink (input valid, input value, input status, output ready);
endinterface

@@ src/decimal_text_to_fixed_point_core.sv @@
// Characters are taken one per cycle while the sequencer is in CT_PARSE and update the
// parser in the cycle they are accepted. A terminator character (NUL) starts a restoring
// division, one quotient bit per cycle, then loads the output register once it is free;
// no character is taken while the divider runs or the result waits to be loaded.
// arst_n clears the parser, sequencer and output valid at once.
module decimal_text_to_fixed_point_core import dtf_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	dtf_char_if.sink     char_in,
	dtf_num_if.source    num_out
);

	localparam logic [INT_BITS-1:0] INT_TOP = {INT_BITS{1'b1}};

	// Parser state.
	phase_t                  phase_q, phase_d;
	logic                    neg_q, neg_d;
	logic [INT_BITS-1:0]     int_q, int_d;
	logic [FRAC_ACC_W-1:0]   frac_q, frac_d;
	logic [DIGIT_CNT_W-1:0]  fd_q, fd_d;
	logic [STATUS_W-1:0]     err_q, err_d;

	// Sequencer and divider.
	ctl_t                    ctl_q, ctl_d;
	ctl_out_t                ctl;
	logic [FRAC_ACC_W-1:0]   rem_q;
	logic [FRAC_ACC_W-1:0]   div_q;
	logic [FRAC_BITS-1:0]    quo_q;
	logic [BIT_CNT_W-1:0]    cnt_q;
	logic [FRAC_ACC_W:0]     rem_shift;
	logic                    rem_ge;

	// Output register.
	logic                    out_valid_q;
	logic [VALUE_W-1:0]      out_value_q;
	logic [STATUS_W-1:0]     out_status_q;

	logic                    char_fire;
	logic                    is_term;
	logic                    is_digit;
	logic                    is_ws;
	logic [3:0]              dval;
	logic [INT_BITS+3:0]     int_next;
	logic                    int_sat;
	logic [FRAC_ACC_W+3:0]   frac_next;
	logic                    out_free;
	logic [VALUE_W-1:0]      mag;
	logic [VALUE_W-1:0]      result;

	assign char_fire = char_in.valid && ctl.in_ready;
	assign is_term   = (char_in.char_code == CH_NUL);
	assign is_digit  = (char_in.char_code >= CH_ZERO) && (char_in.char_code <= CH_NINE);
	assign is_ws     = (char_in.char_code == CH_SPACE) ||
	                   ((char_in.char_code >= CH_TAB) && (char_in.char_code <= CH_CR));
	assign dval      = 4'(char_in.char_code - CH_ZERO);

	// Digit accumulation by shift and add.
	assign int_next  = {1'b0, int_q, 3'b000} + {3'b000, int_q, 1'b0} + (INT_BITS+4)'(dval);
	assign int_sat   = int_next > (INT_BITS+4)'(INT_TOP);
	assign frac_next = {1'b0, frac_q, 3'b000} + {3'b000, frac_q, 1'b0} +
	                   (FRAC_ACC_W+4)'(dval);

	// Parser phase transition.
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_WS: begin
				if (is_ws) begin
					phase_d = PH_WS;
				end else if (char_in.char_code == CH_MINUS || char_in.char_code == CH_PLUS) begin
					phase_d = PH_SIGN;
				end else if (is_digit) begin
					phase_d = PH_INT;
				end else begin
					phase_d = PH_SKIP;
				end
			end
			PH_SIGN: begin
				phase_d = is_digit ? PH_INT : PH_SKIP;
			end
			PH_INT: begin
				if (is_digit) begin
					phase_d = PH_INT;
				end else if (char_in.char_code == CH_POINT) begin
					phase_d = PH_FRAC;
				end else begin
					phase_d = PH_SKIP;
				end
			end
			PH_FRAC: begin
				phase_d = is_digit ? PH_FRAC : PH_SKIP;
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
	end

	// Parser datapath updates.
	always_comb begin
		neg_d  = neg_q;
		int_d  = int_q;
		frac_d = frac_q;
		fd_d   = fd_q;
		err_d  = err_q;
		case (phase_q)
			PH_WS, PH_SIGN: begin
				if (phase_q == PH_WS && char_in.char_code == CH_MINUS) begin
					neg_d = 1'b1;
				end
				if (is_digit) begin
					int_d = int_sat ? INT_TOP : int_next[INT_BITS-1:0];
					if (int_sat) begin
						err_d = ST_SAT;
					end
				end else if (phase_d == PH_SKIP) begin
					err_d = ST_BAD;
				end
			end
			PH_INT: begin
				if (is_digit) begin
					int_d = int_sat ? INT_TOP : int_next[INT_BITS-1:0];
					if (int_sat) begin
						err_d = ST_SAT;
					end
				end
			end
			PH_FRAC: begin
				if (!is_digit) begin
					err_d = ST_BAD;
				end else if (fd_q < DIGIT_CNT_W'(MAX_FRAC_DIGITS)) begin
					frac_d = frac_next[FRAC_ACC_W-1:0];
					fd_d   = fd_q + 1'b1;
				end
			end
			default: begin
				err_d = err_q;
			end
		endcase
	end

	// Sequencer next state.
	always_comb begin
		ctl_d = ctl_q;
		case (ctl_q)
			CT_PARSE: begin
				if (char_fire && is_term) begin
					ctl_d = CT_DIV;
				end
			end
			CT_DIV: begin
				if (cnt_q == BIT_CNT_W'(FRAC_BITS - 1)) begin
					ctl_d = CT_LOAD;
				end
			end
			CT_LOAD: begin
				if (out_free) begin
					ctl_d = CT_PARSE;
				end
			end
			default: begin
				ctl_d = CT_PARSE;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		ctl = '0;
		case (ctl_q)
			CT_PARSE: ctl.in_ready = 1'b1;
			CT_DIV:   ctl.div_step = 1'b1;
			CT_LOAD:  ctl.load_out = out_free;
			default:  ctl = '0;
		endcase
	end

	assign char_in.ready = ctl.in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= CT_PARSE;
		end else begin
			ctl_q <= ctl_d;
		end
	end

	// Parser registers; cleared again once the result is loaded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WS;
			neg_q   <= 1'b0;
			int_q   <= '0;
			frac_q  <= '0;
			fd_q    <= '0;
			err_q   <= ST_OK;
		end else if (ctl.load_out) begin
			phase_q <= PH_WS;
			neg_q   <= 1'b0;
			int_q   <= '0;
			frac_q  <= '0;
			fd_q    <= '0;
			err_q   <= ST_OK;
		end else if (char_fire && !is_term) begin
			phase_q <= phase_d;
			neg_q   <= neg_d;
			int_q   <= int_d;
			frac_q  <= frac_d;
			fd_q    <= fd_d;
			err_q   <= err_d;
		end
	end

	// Restoring divider: one quotient bit of frac * 2^FRAC_BITS / 10^digits per cycle.
	assign rem_shift = {rem_q, 1'b0};
	assign rem_ge    = rem_shift >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (char_fire && is_term) begin
			cnt_q <= '0;
		end else if (ctl.div_step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (char_fire && is_term) begin
			rem_q <= frac_q;
			div_q <= pow10(fd_q);
			quo_q <= '0;
		end else if (ctl.div_step) begin
			rem_q <= rem_ge ? FRAC_ACC_W'(rem_shift - {1'b0, div_q}) : rem_shift[FRAC_ACC_W-1:0];
			quo_q <= {quo_q[FRAC_BITS-2:0], rem_ge};
		end
	end

	// The quotient is below 2^FRAC_BITS, so the magnitude is a plain concatenation.
	assign mag    = VALUE_W'({int_q, quo_q});
	assign result = (err_q == ST_BAD) ? '0 : (neg_q ? (~mag + 1'b1) : mag);

	// Output register: the parser may take new characters while a word waits here.
	assign out_free = !out_valid_q || num_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (num_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			out_value_q  <= result;
			out_status_q <= err_q;
		end
	end

	assign num_out.valid  = out_valid_q;
	assign num_out.value  = out_value_q;
	assign num_out.status = out_status_q;

`ifndef SYNTHESIS
	a_term_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		(char_fire && is_term) |=> (ctl_q == CT_DIV))
		else $error("terminator did not start the divider");

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_q == CT_DIV) |-> (rem_q < div_q))
		else $error("partial remainder not below divisor");

	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(ctl_q == CT_LOAD))
		else $error("result word appeared outside the load step");

	a_digit_limit: assert property (@(posedge clk) disable iff (!arst_n)
		fd_q <= DIGIT_CNT_W'(MAX_FRAC_DIGITS))
		else $error("fraction digit count beyond limit");
`endif

endmodule
